// File: rtl/c_subset_lexer_defines.svh
// Assertion macros for the port-level checks of the lexer (csl_checker).
// No dependencies; included by bare file name.
`ifndef C_SUBSET_LEXER_DEFINES_SVH
`define C_SUBSET_LEXER_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define CSL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lexer check failed");

// Next-cycle implication, disabled while reset is active.
`define CSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lexer check failed");

`endif

// File: rtl/csl_pkg.sv
// Types, constants and helper functions for the C subset lexer.
// No dependencies; used by every lexer module.
package csl_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int LENGTH_BITS_DEF   = 8;
  localparam int QDEPTH            = 4;

  localparam logic [2:0] KPOS_MAX = 3'd7;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_WORD   = 2'd1,
    MODE_NUMBER = 2'd2,
    MODE_FAILED = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    KIND_INT    = 4'd0,
    KIND_RETURN = 4'd1,
    KIND_IDENT  = 4'd2,
    KIND_INTLIT = 4'd3,
    KIND_SEMI   = 4'd4,
    KIND_LPAREN = 4'd5,
    KIND_RPAREN = 4'd6,
    KIND_LBRACE = 4'd7,
    KIND_RBRACE = 4'd8,
    KIND_EQUAL  = 4'd9,
    KIND_ERROR  = 4'd10
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [7:0]  length;
    logic        last;
  } result_t;

  // Results of one byte: count 0..2, valid ones packed from res0.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    res0;
    result_t    res1;
  } lex_out_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    return c == CH_SEMI || c == CH_LPAREN || c == CH_RPAREN ||
           c == CH_LBRACE || c == CH_RBRACE || c == CH_EQUAL;
  endfunction

  function automatic kind_e punct_kind(logic [7:0] c);
    kind_e k;
    unique case (c)
      CH_SEMI:   k = KIND_SEMI;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      default:   k = KIND_EQUAL;
    endcase
    return k;
  endfunction

  function automatic logic int_match(logic [2:0] p, logic [7:0] c);
    logic m;
    case (p)
      3'd0:    m = (c == "i");
      3'd1:    m = (c == "n");
      3'd2:    m = (c == "t");
      default: m = 1'b0;
    endcase
    return m;
  endfunction

  function automatic logic return_match(logic [2:0] p, logic [7:0] c);
    logic m;
    case (p)
      3'd0:    m = (c == "r");
      3'd1:    m = (c == "e");
      3'd2:    m = (c == "t");
      3'd3:    m = (c == "u");
      3'd4:    m = (c == "r");
      3'd5:    m = (c == "n");
      default: m = 1'b0;
    endcase
    return m;
  endfunction

  // bit0 tracks "int", bit1 tracks "return"
  function automatic logic [1:0] kw_alive_next(logic [2:0] p, logic [1:0] alive,
                                               logic [7:0] c);
    return {alive[1] & return_match(p, c), alive[0] & int_match(p, c)};
  endfunction

endpackage

// File: rtl/csl_core.sv
// Lexer state and per-byte step: counters, mode, keyword tracking.
// Depends on csl_pkg. Produces up to two results per accepted byte.
module csl_core #(
  parameter int POSITION_BITS = csl_pkg::POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = csl_pkg::LENGTH_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        ch_i,
  output csl_pkg::lex_out_t lex_o
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0]   LEN_MAX = {LENGTH_BITS{1'b1}};

  csl_pkg::mode_e           mode_q, mode_d;
  logic [POSITION_BITS-1:0] line_q, line_d, col_q, col_d;
  logic [POSITION_BITS-1:0] sline_q, sline_d, scol_q, scol_d;
  logic [LENGTH_BITS-1:0]   len_q, len_d;
  logic [2:0]               kpos_q, kpos_d;
  logic [1:0]               kalive_q, kalive_d;

  logic [POSITION_BITS-1:0] line_n, col_n;
  logic [POSITION_BITS+15:0] line_x, col_x, sline_x, scol_x;
  logic [LENGTH_BITS+7:0]   len_x;
  logic                     alpha, digit, space, punct, cont;
  csl_pkg::kind_e           pend_kind;
  csl_pkg::result_t         pend_res, punct_res, err_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= csl_pkg::MODE_START;
      line_q   <= POSITION_BITS'(1);
      col_q    <= '0;
      sline_q  <= POSITION_BITS'(1);
      scol_q   <= '0;
      len_q    <= '0;
      kpos_q   <= '0;
      kalive_q <= 2'b11;
    end else begin
      mode_q   <= mode_d;
      line_q   <= line_d;
      col_q    <= col_d;
      sline_q  <= sline_d;
      scol_q   <= scol_d;
      len_q    <= len_d;
      kpos_q   <= kpos_d;
      kalive_q <= kalive_d;
    end
  end

  assign alpha = csl_pkg::is_alpha(ch_i);
  assign digit = csl_pkg::is_digit(ch_i);
  assign space = csl_pkg::is_space(ch_i);
  assign punct = csl_pkg::is_punct(ch_i);
  assign cont  = (mode_q == csl_pkg::MODE_WORD && (alpha || digit)) ||
                 (mode_q == csl_pkg::MODE_NUMBER && digit);

  // position of this byte, after the newline or column bump
  always_comb begin
    line_n = line_q;
    col_n  = col_q;
    if (ch_i == csl_pkg::CH_NL) begin
      if (line_q != POS_MAX) line_n = line_q + POSITION_BITS'(1);
      col_n = '0;
    end else if (col_q != POS_MAX) begin
      col_n = col_q + POSITION_BITS'(1);
    end
  end

  // outputs carry the low 16 / 8 bits, zero-extended when narrower
  assign line_x  = {16'd0, line_n};
  assign col_x   = {16'd0, col_n};
  assign sline_x = {16'd0, sline_q};
  assign scol_x  = {16'd0, scol_q};
  assign len_x   = {8'd0, len_q};

  always_comb begin
    if (mode_q == csl_pkg::MODE_NUMBER)                pend_kind = csl_pkg::KIND_INTLIT;
    else if (kalive_q[0] && kpos_q == 3'd3)            pend_kind = csl_pkg::KIND_INT;
    else if (kalive_q[1] && kpos_q == 3'd6)            pend_kind = csl_pkg::KIND_RETURN;
    else                                               pend_kind = csl_pkg::KIND_IDENT;
  end

  always_comb begin
    pend_res.kind    = pend_kind;
    pend_res.line    = sline_x[15:0];
    pend_res.column  = scol_x[15:0];
    pend_res.length  = len_x[7:0];
    pend_res.last    = !punct;
    punct_res.kind   = csl_pkg::punct_kind(ch_i);
    punct_res.line   = line_x[15:0];
    punct_res.column = col_x[15:0];
    punct_res.length = 8'd1;
    punct_res.last   = 1'b1;
    err_res.kind     = csl_pkg::KIND_ERROR;
    err_res.line     = line_x[15:0];
    err_res.column   = col_x[15:0];
    err_res.length   = 8'd0;
    err_res.last     = 1'b1;
  end

  always_comb begin
    mode_d   = mode_q;
    line_d   = line_q;
    col_d    = col_q;
    sline_d  = sline_q;
    scol_d   = scol_q;
    len_d    = len_q;
    kpos_d   = kpos_q;
    kalive_d = kalive_q;
    lex_o    = '0;
    if (step_i && mode_q != csl_pkg::MODE_FAILED) begin
      line_d = line_n;
      col_d  = col_n;
      if (cont) begin
        if (len_q != LEN_MAX) len_d = len_q + LENGTH_BITS'(1);
        if (mode_q == csl_pkg::MODE_WORD) begin
          kalive_d = csl_pkg::kw_alive_next(kpos_q, kalive_q, ch_i);
          if (kpos_q != csl_pkg::KPOS_MAX) kpos_d = kpos_q + 3'd1;
        end
      end else if (mode_q == csl_pkg::MODE_START && (alpha || digit)) begin
        sline_d = line_n;
        scol_d  = col_n;
        len_d   = LENGTH_BITS'(1);
        if (alpha) begin
          mode_d   = csl_pkg::MODE_WORD;
          kalive_d = csl_pkg::kw_alive_next(3'd0, 2'b11, ch_i);
          kpos_d   = 3'd1;
        end else begin
          mode_d   = csl_pkg::MODE_NUMBER;
          kalive_d = 2'b11;
          kpos_d   = 3'd0;
        end
      end else if (!space && !punct) begin
        // bad byte: pending token dropped, block stays failed
        lex_o.cnt  = 2'd1;
        lex_o.res0 = err_res;
        mode_d     = csl_pkg::MODE_FAILED;
      end else if (mode_q != csl_pkg::MODE_START) begin
        mode_d     = csl_pkg::MODE_START;
        lex_o.res0 = pend_res;
        lex_o.res1 = punct_res;
        lex_o.cnt  = punct ? 2'd2 : 2'd1;
      end else if (punct) begin
        lex_o.cnt  = 2'd1;
        lex_o.res0 = punct_res;
      end
    end
  end

endmodule

// File: rtl/csl_out_queue.sv
// Small result queue: up to two results in a cycle, one out if ready.
// Depends on csl_pkg.
module csl_out_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csl_pkg::lex_out_t wr_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output csl_pkg::result_t  head_o,
  output logic              room_o
);

  localparam int PTR_W = $clog2(csl_pkg::QDEPTH);
  localparam int CNT_W = $clog2(csl_pkg::QDEPTH + 1);

  csl_pkg::result_t mem_q [csl_pkg::QDEPTH];
  logic [PTR_W-1:0] wp_q, wp_d, rp_q, rp_d, wp_next;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             rd;

  assign out_valid_o = cnt_q != '0;
  assign rd          = out_valid_o && out_ready_i;
  assign head_o      = mem_q[rp_q];
  // room for two results regardless of the read side
  assign room_o      = cnt_q <= CNT_W'(csl_pkg::QDEPTH - 2);
  assign wp_next     = wp_q + PTR_W'(1);

  always_comb begin
    wp_d  = wp_q + PTR_W'(wr_i.cnt);
    rp_d  = rd ? rp_q + PTR_W'(1) : rp_q;
    cnt_d = cnt_q + CNT_W'(wr_i.cnt) - CNT_W'(rd);
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.cnt != 2'd0) mem_q[wp_q]    <= wr_i.res0;
    if (wr_i.cnt == 2'd2) mem_q[wp_next] <= wr_i.res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: rtl/c_subset_lexer.sv
// Byte-serial lexer for a small C subset: one byte in per cycle, tokens out.
// A token beat is offered the cycle after the byte that ends it, behind any
// beats already queued. Throughput: one byte per cycle; a four-entry result
// queue absorbs bytes that give two tokens, and input stalls only while more
// than two results wait.
// Reset (rst_ni low, async): mode start, line 1, column 0, queue empty.
module c_subset_lexer #(
  parameter int POSITION_BITS = csl_pkg::POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = csl_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  token_kind_o,
  output logic [15:0] token_line_o,
  output logic [15:0] token_column_o,
  output logic [7:0]  token_length_o,
  output logic        last_of_run_o
);

  csl_pkg::lex_out_t lex;
  csl_pkg::result_t  head;
  logic              room;

  assign in_ready_o = room;

  csl_core #(
    .POSITION_BITS(POSITION_BITS),
    .LENGTH_BITS  (LENGTH_BITS)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(in_valid_i && room),
    .ch_i  (ch_i),
    .lex_o (lex)
  );

  csl_out_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (lex),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .head_o     (head),
    .room_o     (room)
  );

  assign token_kind_o   = head.kind;
  assign token_line_o   = head.line;
  assign token_column_o = head.column;
  assign token_length_o = head.length;
  assign last_of_run_o  = head.last;

endmodule

// File: rtl/csl_checker.sv
// Port-level checks for the lexer, bound to the top level.
// Depends on csl_pkg and c_subset_lexer_defines.svh.
`include "c_subset_lexer_defines.svh"

module csl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [3:0]  token_kind_o,
  input logic [15:0] token_line_o,
  input logic [15:0] token_column_o,
  input logic [7:0]  token_length_o,
  input logic        last_of_run_o
);

  logic is_err, is_punct;

  assign is_err   = token_kind_o == csl_pkg::KIND_ERROR;
  assign is_punct = token_kind_o == csl_pkg::KIND_SEMI || token_kind_o == csl_pkg::KIND_LPAREN ||
                    token_kind_o == csl_pkg::KIND_RPAREN || token_kind_o == csl_pkg::KIND_LBRACE ||
                    token_kind_o == csl_pkg::KIND_RBRACE || token_kind_o == csl_pkg::KIND_EQUAL;

  // a stalled beat holds
  `CSL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable({token_kind_o, token_line_o, token_column_o, token_length_o, last_of_run_o}))

  `CSL_ASSERT_IMPLY(a_err_shape, clk_i, rst_ni, out_valid_o && is_err, token_length_o == 8'd0 && last_of_run_o)

  // a punctuator is one byte and always closes its byte's run
  `CSL_ASSERT_IMPLY(a_punct_shape, clk_i, rst_ni, out_valid_o && is_punct, token_length_o == 8'd1 && last_of_run_o)

  // the error is the final beat until reset
  `CSL_ASSERT_NEXT(a_err_final, clk_i, rst_ni, out_valid_o && out_ready_i && is_err, !out_valid_o)

endmodule

bind c_subset_lexer csl_checker u_csl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .token_kind_o  (token_kind_o),
  .token_line_o  (token_line_o),
  .token_column_o(token_column_o),
  .token_length_o(token_length_o),
  .last_of_run_o (last_of_run_o)
);

// File: dv/c_subset_lexer_checker.sv
`timescale 1ns / 1ps
// Token checker for the C subset lexer: tracks accepted source bytes, predicts
// the token beats they cause and compares every token beat. Depends on csl_pkg.
module c_subset_lexer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  ch_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [3:0]  token_kind_i,
  input  logic [15:0] token_line_i,
  input  logic [15:0] token_column_i,
  input  logic [7:0]  token_length_i,
  input  logic        last_of_run_i,
  output int          fail_cnt_o,
  output int          pending_o
);

  localparam logic [23:0] INT_WORD    = "int";
  localparam logic [47:0] RETURN_WORD = "return";
  localparam logic [15:0] POS_SAT     = 16'hFFFF;
  localparam logic [7:0]  LEN_SAT     = 8'hFF;

  csl_pkg::mode_e   mode;
  logic [15:0]      line_cnt;
  logic [15:0]      col_cnt;
  logic [15:0]      tok_line;
  logic [15:0]      tok_col;
  logic [7:0]       tok_len;
  logic [2:0]       kw_pos;
  logic [1:0]       kw_alive;   // bit0: still "int", bit1: still "return"
  csl_pkg::result_t pending_tokens[$];

  function automatic logic letter_ch(input logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
  endfunction

  function automatic logic digit_ch(input logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction

  function automatic logic blank_ch(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // KIND_ERROR marks a byte that is not one of the six punctuators
  function automatic csl_pkg::kind_e punct_of(input logic [7:0] c);
    csl_pkg::kind_e k;
    case (c)
      csl_pkg::CH_SEMI:   k = csl_pkg::KIND_SEMI;
      csl_pkg::CH_LPAREN: k = csl_pkg::KIND_LPAREN;
      csl_pkg::CH_RPAREN: k = csl_pkg::KIND_RPAREN;
      csl_pkg::CH_LBRACE: k = csl_pkg::KIND_LBRACE;
      csl_pkg::CH_RBRACE: k = csl_pkg::KIND_RBRACE;
      csl_pkg::CH_EQUAL:  k = csl_pkg::KIND_EQUAL;
      default:            k = csl_pkg::KIND_ERROR;
    endcase
    return k;
  endfunction

  function automatic csl_pkg::kind_e word_kind();
    csl_pkg::kind_e k;
    if (mode == csl_pkg::MODE_NUMBER) k = csl_pkg::KIND_INTLIT;
    else if (kw_alive[0] && kw_pos == 3'd3) k = csl_pkg::KIND_INT;
    else if (kw_alive[1] && kw_pos == 3'd6) k = csl_pkg::KIND_RETURN;
    else k = csl_pkg::KIND_IDENT;
    return k;
  endfunction

  task automatic match_keyword(input logic [7:0] c);
    int p;
    p = kw_pos;
    if (p >= 3) kw_alive[0] = 1'b0;
    else if (c != INT_WORD[23 - 8*p -: 8]) kw_alive[0] = 1'b0;
    if (p >= 6) kw_alive[1] = 1'b0;
    else if (c != RETURN_WORD[47 - 8*p -: 8]) kw_alive[1] = 1'b0;
    if (kw_pos != 3'd7) kw_pos++;
  endtask

  task automatic lex_byte(input logic [7:0] c);
    csl_pkg::result_t found [2];
    int               n;
    csl_pkg::kind_e   pk;
    n = 0;
    if (mode == csl_pkg::MODE_FAILED) return;
    if (c == csl_pkg::CH_NL) begin
      if (line_cnt != POS_SAT) line_cnt++;
      col_cnt = '0;
    end else if (col_cnt != POS_SAT) begin
      col_cnt++;
    end
    if ((mode == csl_pkg::MODE_WORD && (letter_ch(c) || digit_ch(c))) ||
        (mode == csl_pkg::MODE_NUMBER && digit_ch(c))) begin
      if (tok_len != LEN_SAT) tok_len++;
      if (mode == csl_pkg::MODE_WORD) match_keyword(c);
      return;
    end
    if (mode == csl_pkg::MODE_START && (letter_ch(c) || digit_ch(c))) begin
      tok_line = line_cnt;
      tok_col  = col_cnt;
      tok_len  = 8'd1;
      kw_pos   = '0;
      kw_alive = 2'b11;
      if (letter_ch(c)) begin
        mode = csl_pkg::MODE_WORD;
        match_keyword(c);
      end else begin
        mode = csl_pkg::MODE_NUMBER;
      end
      return;
    end
    pk = punct_of(c);
    if (!blank_ch(c) && pk == csl_pkg::KIND_ERROR) begin
      // pending word or number is dropped, lexer stays failed
      found[0] = '{csl_pkg::KIND_ERROR, line_cnt, col_cnt, 8'd0, 1'b0};
      n = 1;
      mode = csl_pkg::MODE_FAILED;
    end else begin
      if (mode != csl_pkg::MODE_START) begin
        found[n] = '{word_kind(), tok_line, tok_col, tok_len, 1'b0};
        n++;
        mode = csl_pkg::MODE_START;
      end
      if (pk != csl_pkg::KIND_ERROR) begin
        found[n] = '{pk, line_cnt, col_cnt, 8'd1, 1'b0};
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      found[i].last = (i == n - 1);
      pending_tokens.insert(pending_tokens.size(), found[i]);
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    csl_pkg::result_t want;
    if (!rst_ni) begin
      mode       = csl_pkg::MODE_START;
      line_cnt   = 16'd1;
      col_cnt    = '0;
      tok_line   = 16'd1;
      tok_col    = '0;
      tok_len    = '0;
      kw_pos     = '0;
      kw_alive   = 2'b11;
      fail_cnt_o = 0;
      pending_tokens.delete();
    end else begin
      // a token beat can never stem from a byte taken at this same edge
      if (out_valid_i && out_ready_i) begin
        if (pending_tokens.size() == 0) begin
          $error("token beat with none expected: kind %0d line %0d column %0d",
                 token_kind_i, token_line_i, token_column_i);
          fail_cnt_o++;
        end else begin
          want = pending_tokens.pop_front();
          check_field("token_kind", want.kind, token_kind_i);
          check_field("token_line", want.line, token_line_i);
          check_field("token_column", want.column, token_column_i);
          check_field("token_length", want.length, token_length_i);
          check_field("last_of_run", want.last, last_of_run_i);
        end
      end
      if (in_valid_i && in_ready_i) lex_byte(ch_i);
    end
    pending_o = pending_tokens.size();
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Top of the lexer testbench: clock, reset, source byte stimulus, token sink
// and verdict. Depends on csl_pkg, c_subset_lexer and c_subset_lexer_checker.
module tb;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_BYTES = 1100;
  localparam int HOLD_AT      = 600;
  localparam int HOLD_LEN     = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  ch_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [3:0]  token_kind_o;
  logic [15:0] token_line_o;
  logic [15:0] token_column_o;
  logic [7:0]  token_length_o;
  logic        last_of_run_o;

  int fail_cnt;
  int pending_cnt;
  int cycle_cnt;
  int bytes_sent;
  int burst_left;
  bit full_rate;

  string near_words [13] = '{"int", "return", "in", "i", "inT", "intt", "int0",
                             "ret", "retur", "returnn", "Return", "return9", "rint"};
  // punctuation outside the six punctuators
  string stray_punct = "!\"#$%&'*+,-./:<>?@[\\]^_\140|~";

  c_subset_lexer i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .ch_i,
    .out_valid_o,
    .out_ready_i,
    .token_kind_o,
    .token_line_o,
    .token_column_o,
    .token_length_o,
    .last_of_run_o
  );

  c_subset_lexer_checker i_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i     (in_ready_o),
    .ch_i,
    .out_valid_i    (out_valid_o),
    .out_ready_i,
    .token_kind_i   (token_kind_o),
    .token_line_i   (token_line_o),
    .token_column_i (token_column_o),
    .token_length_i (token_length_o),
    .last_of_run_i  (last_of_run_o),
    .fail_cnt_o     (fail_cnt),
    .pending_o      (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // token sink: stall pattern of its own, one long hold-off to back up the lexer
  initial begin : sink
    int style;
    int len;
    bit held;
    held        = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && cycle_cnt >= HOLD_AT) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk_i);
      end
      style = $urandom_range(0, 3);
      len   = $urandom_range(1, 40);
      repeat (len) begin
        @(negedge clk_i);
        case (style)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= $urandom_range(0, 1);
          2:       out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(65, 90))
                                       : 8'($urandom_range(97, 122));
  endfunction

  function automatic logic [7:0] rand_blank();
    logic [7:0] b;
    case ($urandom_range(0, 5))
      0, 1:    b = csl_pkg::CH_SPACE;
      2:       b = csl_pkg::CH_NL;
      default: b = 8'($urandom_range(9, 13));
    endcase
    return b;
  endfunction

  function automatic logic [7:0] rand_punct();
    logic [7:0] b;
    case ($urandom_range(0, 5))
      0:       b = csl_pkg::CH_SEMI;
      1:       b = csl_pkg::CH_LPAREN;
      2:       b = csl_pkg::CH_RPAREN;
      3:       b = csl_pkg::CH_LBRACE;
      4:       b = csl_pkg::CH_RBRACE;
      default: b = csl_pkg::CH_EQUAL;
    endcase
    return b;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (!full_rate) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0)
          gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 5);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i       <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // one well-formed token with the delimiters that follow it
  task automatic send_token();
    int shape;
    int len;
    bit needs_delim;
    shape       = $urandom_range(0, 9);
    needs_delim = 1'b1;
    len = ($urandom_range(0, 59) == 0) ? $urandom_range(250, 300) : $urandom_range(1, 12);
    case (shape)
      0, 1, 2: begin
        send_byte(rand_letter());
        repeat (len - 1)
          send_byte(($urandom_range(0, 2) == 0) ? 8'($urandom_range(48, 57)) : rand_letter());
      end
      3: send_text(near_words[$urandom_range(0, 12)]);
      4: repeat (len) send_byte(8'($urandom_range(48, 57)));
      5, 6, 7: begin
        send_byte(rand_punct());
        needs_delim = 1'b0;
      end
      default: begin
        send_byte(rand_blank());
        needs_delim = 1'b0;
      end
    endcase
    if (needs_delim && $urandom_range(0, 1) != 0) send_byte(rand_punct());
    else if (needs_delim) repeat ($urandom_range(1, 3)) send_byte(rand_blank());
    else repeat ($urandom_range(0, 2)) send_byte(rand_blank());
  endtask

  initial begin : stimulus
    int first;
    in_valid_i = 1'b0;
    ch_i       = '0;
    rst_ni     = 1'b0;
    full_rate  = 1'b0;
    burst_left = 0;
    bytes_sent = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // keywords, near keyword, number, every punctuator and blank kind
    send_text("int return intx=7;(\011)\013{\014}\015\n");

    first = bytes_sent;
    while (bytes_sent < first + RANDOM_BYTES) send_token();

    // bytes back to back, no idle cycles on the input
    full_rate = 1'b1;
    send_text("returnxyz12 int=9;\n");
    repeat (20) send_token();
    full_rate = 1'b0;
    repeat (20) send_token();

    // one bad byte ends lexing for good; later bytes are dropped
    case ($urandom_range(0, 3))
      0: begin
        send_text("12");
        send_byte(rand_letter());
      end
      1: begin
        send_text("abc");
        send_byte(8'($urandom_range(128, 255)));
      end
      2: send_byte(stray_punct[$urandom_range(0, stray_punct.len() - 1)]);
      default: send_byte(($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 8))
                                                     : 8'($urandom_range(14, 31)));
    endcase
    send_byte(8'hFF);
    send_byte(8'h7F);
    repeat (14) send_byte(8'($urandom_range(0, 255)));
    in_valid_i <= 1'b0;

    while (pending_cnt != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/csl_pkg.sv
rtl/csl_core.sv
rtl/csl_out_queue.sv
rtl/c_subset_lexer.sv
rtl/csl_checker.sv
dv/c_subset_lexer_checker.sv
dv/tb.sv
